>>> design/sll_pkg.sv
// Shared types and constants for the stereo look-ahead limiter.
`default_nettype none
package sll_pkg;

	localparam int SW = 24;
	localparam int CW = 25;
	localparam int LVW = 28;
	localparam int ACCW = 56;
	localparam int MUL_STEPS = 25;
	localparam int DIV_STEPS = 48;

	localparam logic [CW-1:0] ONE_Q24 = 25'h1000000;

	localparam logic [2:0] REG_DETECTOR_GAIN = 3'd0;
	localparam logic [2:0] REG_MAKEUP_GAIN = 3'd1;
	localparam logic [2:0] REG_LIMIT_LEVEL = 3'd2;
	localparam logic [2:0] REG_ATTACK = 3'd3;
	localparam logic [2:0] REG_RELEASE = 3'd4;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_MUL,
		S_STORE,
		S_DIVSET,
		S_DIV,
		S_DIVEND,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_LA,
		OP_RA,
		OP_LL_OLD,
		OP_LL_NEW,
		OP_RL_OLD,
		OP_RL_NEW,
		OP_G_OLD,
		OP_G_NEW,
		OP_TL,
		OP_OL,
		OP_TR,
		OP_OR
	} op_t;

endpackage
`default_nettype wire

>>> design/stereo_lookahead_limiter_core.sv
// Stereo linked look-ahead peak limiter core with bit-serial arithmetic.
`default_nettype none
// One stereo pair per word in, one limited pair per word out. All arithmetic runs on one
// shared bit-serial multiply-accumulate unit (a load state, the serial multiply and a store
// state per product, twelve products per word) and a restoring divider that produces one
// quotient bit per cycle (between a set-up and a finish state). The next word can be accepted
// in the cycle after the result is registered, not before; a zero peak skips the divide and so
// shortens the work per word.
// A finished result sits in the output register while the next word is accepted; the one after
// it waits, with the input stalled, until that register is taken. The delay
// line is one memory of MAX_LOOKAHEAD entries; a fill count stands in for clearing it.
// Configuration may be written at any time the core is idle; cfg_ready is always high.
module stereo_lookahead_limiter_core #(
	parameter int MAX_LOOKAHEAD = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [sll_pkg::SW-1:0] left_in,
	input  wire logic signed [sll_pkg::SW-1:0] right_in,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [sll_pkg::SW-1:0]   left_out,
	output logic signed [sll_pkg::SW-1:0]   right_out,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [sll_pkg::CW-1:0]     cfg_data
);
	import sll_pkg::*;

	localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
	localparam int FW = $clog2(MAX_LOOKAHEAD + 1);

	state_t state_q, state_d;
	op_t    op_q;

	logic [15:0]   dg_q, mg_q;
	logic [23:0]   limit_q;
	logic [CW-1:0] atk_reg_q, rel_reg_q;
	logic [8:0]    look_q;

	logic [AW-1:0] ptr_q;
	logic [FW-1:0] fill_q;
	logic [47:0]   hist_mem [MAX_LOOKAHEAD];
	logic [47:0]   rd_q;
	logic          nodelay_q, zero_q;

	logic signed [SW-1:0] l_q, r_q, dl_q, dr_q;
	logic [LVW-1:0] la_q, ra_q, llev_q, rlev_q;
	logic [CW-1:0]  gain_q, target_q;
	logic signed [CW-1:0] t_q;
	logic signed [SW-1:0] lo_q, ro_q;

	logic signed [ACCW-1:0] acc_q, mc_q;
	logic [CW-1:0] mp_q;
	logic [4:0]    mcnt_q;

	logic [47:0]    dvd_q;
	logic [LVW-1:0] rem_q;
	logic [CW-1:0]  quo_q;
	logic           ovf_q;
	logic [5:0]     dcnt_q;

	logic           out_valid_q;
	logic signed [SW-1:0] left_out_q, right_out_q;

	logic accept, emit_go;
	logic [31:0] len_full, idx_full;
	logic [FW-1:0] len;
	logic [AW-1:0] rd_idx;
	logic [CW-1:0] atk, rel, cl, cr, cg;
	logic [LVW-1:0] peak;
	logic signed [ACCW-1:0] acc_init, mc_init;
	logic [CW-1:0] mp_init;
	logic acc_keep;
	logic [SW-1:0] l_mag, r_mag;
	logic [LVW:0] trial;
	logic ge;
	logic signed [43:0] o_full;
	logic signed [SW-1:0] o_sat;

	assign atk = (atk_reg_q > ONE_Q24) ? ONE_Q24 : atk_reg_q;
	assign rel = (rel_reg_q > ONE_Q24) ? ONE_Q24 : rel_reg_q;
	assign cl = (la_q > llev_q) ? atk : rel;
	assign cr = (ra_q > rlev_q) ? atk : rel;
	assign cg = (target_q < gain_q) ? atk : rel;
	assign peak = (llev_q > rlev_q) ? llev_q : rlev_q;
	assign l_mag = l_q[SW-1] ? (~l_q + 24'd1) : l_q;
	assign r_mag = r_q[SW-1] ? (~r_q + 24'd1) : r_q;

	assign len_full = (32'(look_q) > 32'(MAX_LOOKAHEAD)) ? 32'(MAX_LOOKAHEAD) : 32'(look_q);
	assign len = len_full[FW-1:0];
	always_comb begin
		idx_full = 32'(ptr_q) + 32'(MAX_LOOKAHEAD) - len_full;
		if (idx_full >= 32'(MAX_LOOKAHEAD))
			idx_full = idx_full - 32'(MAX_LOOKAHEAD);
	end
	assign rd_idx = idx_full[AW-1:0];

	assign trial = {rem_q, dvd_q[47]};
	assign ge = trial >= {1'b0, peak};

	assign o_full = acc_q[ACCW-1:12];
	always_comb begin
		if (o_full > 44'sd8388607)
			o_sat = 24'sh7fffff;
		else if (o_full < -44'sd8388608)
			o_sat = 24'sh800000;
		else
			o_sat = o_full[SW-1:0];
	end

	always_comb begin
		acc_keep = 1'b0;
		acc_init = '0;
		mc_init = '0;
		mp_init = '0;
		case (op_q)
			OP_LA: begin
				mc_init = {32'b0, l_mag};
				mp_init = {9'b0, dg_q};
			end
			OP_RA: begin
				mc_init = {32'b0, r_mag};
				mp_init = {9'b0, dg_q};
			end
			OP_LL_OLD: begin
				acc_init = 56'sd8388608;
				mc_init = {28'b0, llev_q};
				mp_init = ONE_Q24 - cl;
			end
			OP_LL_NEW: begin
				acc_keep = 1'b1;
				mc_init = {28'b0, la_q};
				mp_init = cl;
			end
			OP_RL_OLD: begin
				acc_init = 56'sd8388608;
				mc_init = {28'b0, rlev_q};
				mp_init = ONE_Q24 - cr;
			end
			OP_RL_NEW: begin
				acc_keep = 1'b1;
				mc_init = {28'b0, ra_q};
				mp_init = cr;
			end
			OP_G_OLD: begin
				acc_init = 56'sd8388608;
				mc_init = {31'b0, gain_q};
				mp_init = ONE_Q24 - cg;
			end
			OP_G_NEW: begin
				acc_keep = 1'b1;
				mc_init = {31'b0, target_q};
				mp_init = cg;
			end
			OP_TL: begin
				acc_init = 56'sd8388608;
				mc_init = {{32{dl_q[SW-1]}}, dl_q};
				mp_init = gain_q;
			end
			OP_TR: begin
				acc_init = 56'sd8388608;
				mc_init = {{32{dr_q[SW-1]}}, dr_q};
				mp_init = gain_q;
			end
			OP_OL, OP_OR: begin
				acc_init = 56'sd2048;
				mc_init = {{31{t_q[CW-1]}}, t_q};
				mp_init = {9'b0, mg_q};
			end
			default: begin
				acc_keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_FETCH;
			S_FETCH:  state_d = S_LOAD;
			S_LOAD:   state_d = S_MUL;
			S_MUL:    if (mcnt_q == 5'(MUL_STEPS - 1)) state_d = S_STORE;
			S_STORE: begin
				if (op_q == OP_RL_NEW)
					state_d = S_DIVSET;
				else if (op_q == OP_OR)
					state_d = S_EMIT;
				else
					state_d = S_LOAD;
			end
			S_DIVSET: state_d = (peak == '0) ? S_LOAD : S_DIV;
			S_DIV:    if (dcnt_q == 6'(DIV_STEPS - 1)) state_d = S_DIVEND;
			S_DIVEND: state_d = S_LOAD;
			S_EMIT:   if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		accept = in_valid && (state_q == S_IDLE);
		emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
		cfg_ready = 1'b1;
		out_valid = out_valid_q;
		left_out = left_out_q;
		right_out = right_out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_LA;
			dg_q <= 16'd4096;
			mg_q <= 16'd4096;
			limit_q <= 24'd8388608;
			atk_reg_q <= ONE_Q24;
			rel_reg_q <= 25'd6964;
			look_q <= 9'd5;
			ptr_q <= '0;
			fill_q <= '0;
			llev_q <= '0;
			rlev_q <= '0;
			gain_q <= ONE_Q24;
			out_valid_q <= 1'b0;
			mcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_DETECTOR_GAIN: dg_q <= cfg_data[15:0];
					REG_MAKEUP_GAIN:   mg_q <= cfg_data[15:0];
					REG_LIMIT_LEVEL:   limit_q <= cfg_data[23:0];
					REG_ATTACK:        atk_reg_q <= cfg_data;
					REG_RELEASE:       rel_reg_q <= cfg_data;
					REG_LOOKAHEAD:     look_q <= cfg_data[8:0];
					default:           ;
				endcase
			end
			if (accept && len != '0) begin
				ptr_q <= (32'(ptr_q) == 32'(MAX_LOOKAHEAD - 1)) ? '0 : ptr_q + AW'(1);
				if (32'(fill_q) < 32'(MAX_LOOKAHEAD))
					fill_q <= fill_q + FW'(1);
			end
			if (state_q == S_FETCH)
				op_q <= OP_LA;
			if (state_q == S_LOAD)
				mcnt_q <= '0;
			if (state_q == S_MUL)
				mcnt_q <= mcnt_q + 5'd1;
			if (state_q == S_DIVSET)
				dcnt_q <= '0;
			if (state_q == S_DIV)
				dcnt_q <= dcnt_q + 6'd1;
			if (state_q == S_STORE) begin
				op_q <= op_t'(op_q + 4'd1);
				case (op_q)
					OP_LL_NEW: llev_q <= acc_q[51:24];
					OP_RL_NEW: rlev_q <= acc_q[51:24];
					OP_G_NEW:  gain_q <= acc_q[48:24];
					default:   ;
				endcase
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_q <= left_in;
			r_q <= right_in;
			nodelay_q <= (len == '0);
			zero_q <= (len != '0) && (32'(fill_q) < len_full);
			rd_q <= hist_mem[rd_idx];
			if (len != '0)
				hist_mem[ptr_q] <= {left_in, right_in};
		end
		if (state_q == S_FETCH) begin
			dl_q <= nodelay_q ? l_q : (zero_q ? '0 : rd_q[47:24]);
			dr_q <= nodelay_q ? r_q : (zero_q ? '0 : rd_q[23:0]);
		end
		if (state_q == S_LOAD) begin
			if (!acc_keep)
				acc_q <= acc_init;
			mc_q <= mc_init;
			mp_q <= mp_init;
		end
		if (state_q == S_MUL) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
		if (state_q == S_STORE) begin
			case (op_q)
				OP_LA:   la_q <= acc_q[39:12];
				OP_RA:   ra_q <= acc_q[39:12];
				OP_TL:   t_q <= acc_q[48:24];
				OP_TR:   t_q <= acc_q[48:24];
				OP_OL:   lo_q <= o_sat;
				OP_OR:   ro_q <= o_sat;
				default: ;
			endcase
		end
		if (state_q == S_DIVSET) begin
			target_q <= ONE_Q24;
			dvd_q <= {limit_q, 24'b0};
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end
		if (state_q == S_DIV) begin
			rem_q <= ge ? LVW'(trial - {1'b0, peak}) : trial[LVW-1:0];
			quo_q <= {quo_q[CW-2:0], ge};
			ovf_q <= ovf_q | quo_q[CW-1];
			dvd_q <= {dvd_q[46:0], 1'b0};
		end
		if (state_q == S_DIVEND)
			target_q <= (ovf_q || quo_q > ONE_Q24) ? ONE_Q24 : quo_q;
		if (emit_go) begin
			left_out_q <= lo_q;
			right_out_q <= ro_q;
		end
	end

endmodule
`default_nettype wire
